[rtl/core/lap3d_pkg.sv]
// shared types, widths and constants of the 3d laplacian column generator
package lap3d_pkg;

   localparam int DIM_W   = 9;
   localparam int COL_W   = 25;
   localparam int OFF_W   = 26;
   localparam int PROD_W  = 2 * DIM_W;
   localparam int NENT_W  = 3;
   localparam int IDX_W   = 2;
   localparam int NROWS   = 4;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // largest usable grid extent along any axis
   localparam int DIM_MAX = 256;
   localparam logic [DIM_W-1:0] DIM_CLAMP = DIM_W'(DIM_MAX);

   // register indexes of the configuration port
   localparam logic [IDX_W-1:0] REG_DIM_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_DIM_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_DIM_Z = 2'd2;

   localparam logic signed [3:0] VAL_DIAG = 4'sd6;
   localparam logic signed [3:0] VAL_OFF  = -4'sd1;

   // one column as handed from the front to the back
   typedef struct packed {
      logic [COL_W-1:0]            column;
      logic [OFF_W-1:0]            column_start;
      logic [NROWS-1:0][COL_W-1:0] rows;      // diag, +1, +x, +x*y
      logic [NROWS-1:0]            present;   // which rows exist
      logic                        rhs;
      logic                        last_col;
   } col_entry_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) begin
         return DIM_W'(1);
      end else if (v > DIM_CLAMP) begin
         return DIM_CLAMP;
      end
      return v;
   endfunction

endpackage

[rtl/core/lap3d_chan_if.sv]
// channel interfaces: request, result and configuration write
interface lap3d_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface lap3d_rsp_if;
   import lap3d_pkg::*;
   logic                valid;
   logic                ready;
   logic [COL_W-1:0]    column;
   logic [COL_W-1:0]    row;
   logic signed [3:0]   entry_value;
   logic [OFF_W-1:0]    column_start;
   logic                rhs_value;
   logic                last_in_column;
   logic                last_of_matrix;

   modport source (output valid, output column, output row, output entry_value,
                   output column_start, output rhs_value, output last_in_column,
                   output last_of_matrix, input ready);
   modport sink   (input valid, input column, input row, input entry_value,
                   input column_start, input rhs_value, input last_in_column,
                   input last_of_matrix, output ready);
endinterface

interface lap3d_csr_if;
   import lap3d_pkg::*;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [DIM_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/lap3d_front.sv]
// front end: config registers, grid counters and per-column classification
module lap3d_front (
   input  logic                     clock,
   input  logic                     reset,
   lap3d_req_if.sink                req_chan,
   lap3d_csr_if.sink                csr_chan,
   input  logic                     q_full,
   output logic                     q_push,
   output lap3d_pkg::col_entry_type q_data
);
   import lap3d_pkg::*;

   logic [DIM_W-1:0]  dim_x_ff, dim_x_in, dim_y_ff, dim_y_in, dim_z_ff, dim_z_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              settle_ff, settle_in;
   logic [DIM_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [COL_W-1:0]  col_idx_ff, col_idx_in;
   logic [OFF_W-1:0]  next_off_ff, next_off_in;
   logic              finished_ff, finished_in;

   logic [DIM_W-1:0]  dx, dy, dz;
   logic [DIM_W-1:0]  px, py, pz;
   logic [COL_W-1:0]  ci, l;
   logic [OFF_W-1:0]  start;
   logic              fin, xe, ye, ze, last_col, accept, csr_fire;
   logic [NENT_W-1:0] n_ent;

   assign dx = eff_dim(dim_x_ff);
   assign dy = eff_dim(dim_y_ff);
   assign dz = eff_dim(dim_z_ff);

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;
   // hold off in the cycle after a write so the product register catches up
   assign req_chan.ready = !q_full && !settle_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      // restart state takes effect in the same step
      px    = req_chan.restart ? DIM_W'(1) : pos_x_ff;
      py    = req_chan.restart ? '0 : pos_y_ff;
      pz    = req_chan.restart ? '0 : pos_z_ff;
      ci    = req_chan.restart ? '0 : col_idx_ff;
      start = req_chan.restart ? OFF_W'(1) : next_off_ff;
      fin   = req_chan.restart ? 1'b0 : finished_ff;

      l        = ci + COL_W'(1);
      xe       = px >= dx;
      ye       = py >= (dy - DIM_W'(1));
      ze       = pz >= (dz - DIM_W'(1));
      last_col = xe && ye && ze;
      n_ent    = NENT_W'(1) + {2'b00, !xe} + {2'b00, !ye} + {2'b00, !ze};

      q_data.column       = l;
      q_data.column_start = start;
      q_data.rows[0]      = l;
      q_data.rows[1]      = l + COL_W'(1);
      q_data.rows[2]      = l + COL_W'(dx);
      q_data.rows[3]      = l + COL_W'(prod_ff);
      q_data.present      = {!ze, !ye, !xe, 1'b1};
      q_data.rhs          = (ci == '0) || last_col;
      q_data.last_col     = last_col;
      q_push              = accept && !fin;
   end

   always_comb begin
      dim_x_in    = dim_x_ff;
      dim_y_in    = dim_y_ff;
      dim_z_in    = dim_z_ff;
      prod_in     = PROD_W'(dx) * PROD_W'(dy);
      settle_in   = csr_fire;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      pos_z_in    = pos_z_ff;
      col_idx_in  = col_idx_ff;
      next_off_in = next_off_ff;
      finished_in = finished_ff;

      if (csr_fire) begin
         case (csr_chan.index)
            REG_DIM_X: dim_x_in = csr_chan.data;
            REG_DIM_Y: dim_y_in = csr_chan.data;
            REG_DIM_Z: dim_z_in = csr_chan.data;
            default:   ;
         endcase
      end

      if (accept && !fin) begin
         col_idx_in  = l;
         next_off_in = start + OFF_W'(n_ent);
         finished_in = 1'b0;
         pos_x_in    = px;
         pos_y_in    = py;
         pos_z_in    = pz;
         if (last_col) begin
            finished_in = 1'b1;
         end else if (!xe) begin
            pos_x_in = px + DIM_W'(1);
         end else begin
            pos_x_in = DIM_W'(1);
            if (!ye) begin
               pos_y_in = py + DIM_W'(1);
            end else begin
               pos_y_in = '0;
               pos_z_in = pz + DIM_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         dim_x_ff    <= DIM_W'(1);
         dim_y_ff    <= DIM_W'(1);
         dim_z_ff    <= DIM_W'(1);
         settle_ff   <= 1'b1;
         pos_x_ff    <= DIM_W'(1);
         pos_y_ff    <= '0;
         pos_z_ff    <= '0;
         col_idx_ff  <= '0;
         next_off_ff <= OFF_W'(1);
         finished_ff <= 1'b0;
      end else begin
         dim_x_ff    <= dim_x_in;
         dim_y_ff    <= dim_y_in;
         dim_z_ff    <= dim_z_in;
         settle_ff   <= settle_in;
         pos_x_ff    <= pos_x_in;
         pos_y_ff    <= pos_y_in;
         pos_z_ff    <= pos_z_in;
         col_idx_ff  <= col_idx_in;
         next_off_ff <= next_off_in;
         finished_ff <= finished_in;
      end
   end

endmodule

[rtl/core/lap3d_queue.sv]
// short column queue between front and back
module lap3d_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lap3d_pkg::col_entry_type push_data,
   output logic                     full,
   input  logic                     pop,
   output lap3d_pkg::col_entry_type pop_data,
   output logic                     empty
);
   import lap3d_pkg::*;

   col_entry_type     slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == QCNT_W'(QDEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/core/lap3d_back.sv]
// back end: walks one column's entries, one per cycle while the output register is free, into the output register
module lap3d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  lap3d_pkg::col_entry_type q_data,
   output logic                     q_pop,
   lap3d_rsp_if.source              rsp_chan
);
   import lap3d_pkg::*;

   col_entry_type     cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [NROWS-1:0]  rem_ff, rem_in;
   logic              out_valid_ff, out_valid_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in, out_row_ff, out_row_in;
   logic signed [3:0] out_val_ff, out_val_in;
   logic [OFF_W-1:0]  out_start_ff, out_start_in;
   logic              out_rhs_ff, out_rhs_in, out_lic_ff, out_lic_in;
   logic              out_lom_ff, out_lom_in;

   logic [NROWS-1:0]  low_bit;
   logic [IDX_W-1:0]  sel;
   logic              out_free, fire, last_ent;

   always_comb begin
      low_bit  = rem_ff & (~rem_ff + NROWS'(1));
      last_ent = (rem_ff & ~low_bit) == '0;
      if (rem_ff[0]) begin
         sel = 2'd0;
      end else if (rem_ff[1]) begin
         sel = 2'd1;
      end else if (rem_ff[2]) begin
         sel = 2'd2;
      end else begin
         sel = 2'd3;
      end
      out_free = !out_valid_ff || rsp_chan.ready;
      fire     = cur_valid_ff && out_free;
      q_pop    = !q_empty && (!cur_valid_ff || (fire && last_ent));

      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      rem_in       = rem_ff;
      if (fire) begin
         rem_in = rem_ff & ~low_bit;
         if (last_ent) begin
            cur_valid_in = 1'b0;
         end
      end
      if (q_pop) begin
         cur_in       = q_data;
         cur_valid_in = 1'b1;
         rem_in       = q_data.present;
      end

      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_val_in   = out_val_ff;
      out_start_in = out_start_ff;
      out_rhs_in   = out_rhs_ff;
      out_lic_in   = out_lic_ff;
      out_lom_in   = out_lom_ff;
      if (fire) begin
         out_valid_in = 1'b1;
         out_col_in   = cur_ff.column;
         out_row_in   = cur_ff.rows[sel];
         out_val_in   = (sel == '0) ? VAL_DIAG : VAL_OFF;
         out_start_in = cur_ff.column_start;
         out_rhs_in   = cur_ff.rhs;
         out_lic_in   = last_ent;
         out_lom_in   = last_ent && cur_ff.last_col;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.column         = out_col_ff;
   assign rsp_chan.row            = out_row_ff;
   assign rsp_chan.entry_value    = out_val_ff;
   assign rsp_chan.column_start   = out_start_ff;
   assign rsp_chan.rhs_value      = out_rhs_ff;
   assign rsp_chan.last_in_column = out_lic_ff;
   assign rsp_chan.last_of_matrix = out_lom_ff;

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_val_ff   <= out_val_in;
      out_start_ff <= out_start_in;
      out_rhs_ff   <= out_rhs_in;
      out_lic_ff   <= out_lic_in;
      out_lom_ff   <= out_lom_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[rtl/core/laplacian_3d_csc_generator_top.sv]
// top level of the 3d seven-point laplacian lower-triangle csc generator
// usage:
//  - csr_chan writes the grid extents dim_x, dim_y, dim_z (index 0, 1, 2);
//    a value of 0 acts as 1 and values above the grid limit are clamped
//  - each item on req_chan asks for the next column (restart = 1 begins again
//    at column 1); it yields 1 to 4 entries on rsp_chan: the diagonal (6),
//    then -1 at rows +1, +x and +x*y where that neighbor exists
//  - once the last column is out, items without restart yield nothing
// timing:
//  - a request is taken while the column queue has room; the first entry of a
//    column passes the queue, then the back end's column and output registers
//  - the back end sends one entry per cycle from its output register while the
//    receiver is ready; that entry walk, 4 entries for an interior point, is
//    what bounds the sustained rate
//  - req_chan.ready drops in the cycle after every configuration write
// reset clears the counters and the queue and sets all extents to 1;
// when the receiver stalls, the output holds, the queue fills and ready drops
module laplacian_3d_csc_generator_top (
   input logic         clock,
   input logic         reset,
   lap3d_req_if.sink   req_chan,
   lap3d_rsp_if.source rsp_chan,
   lap3d_csr_if.sink   csr_chan
);
   import lap3d_pkg::*;

   // front to queue
   logic          q_push, q_full;
   col_entry_type q_push_data;
   // queue to back
   logic          q_pop, q_empty;
   col_entry_type q_pop_data;

   lap3d_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   lap3d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   lap3d_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_pop_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // the queue is never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("column queue written while full");

   // no request is taken in the cycle after a configuration write
   a_cfg_settle: assert property (@(posedge clock) disable iff (reset)
      (csr_chan.valid && csr_chan.ready) |=> !req_chan.ready)
      else $error("request taken before product register settled");

   // the diagonal entry sits on its own column
   a_diag_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.entry_value == VAL_DIAG)
         |-> (rsp_chan.row == rsp_chan.column))
      else $error("diagonal entry off the diagonal");

   // end of matrix only on a column's final entry
   a_last_of_matrix: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last_of_matrix) |-> rsp_chan.last_in_column)
      else $error("end of matrix flagged mid-column");

endmodule

[verif/laplacian_3d_csc_generator_top_tb.sv]
// self-checking testbench for the 3d laplacian lower-triangle csc column generator
`timescale 1ns / 100ps

module laplacian_3d_csc_generator_top_tb;
   import lap3d_pkg::*;

   localparam int SETTLE_CYCLES = 12;    // covers the request-to-entry latency with margin
   localparam int LONG_STALL    = 400;   // receiver hold-off that backs up the column queue
   localparam int WATCHDOG_MAX  = 4000;  // cycles without any handshake before giving up
   localparam int RANDOM_COLS   = 500;   // productive requests in the random part

   // one matrix entry as it leaves the block
   typedef struct packed {
      logic [COL_W-1:0]  column;
      logic [COL_W-1:0]  row;
      logic signed [3:0] entry_value;
      logic [OFF_W-1:0]  column_start;
      logic              rhs_value;
      logic              last_in_column;
      logic              last_of_matrix;
   } lap_entry_type;

   typedef enum logic {STEP_CSR, STEP_REQ} step_kind_type;

   // one row of the directed stimulus table; lit_n < 0 means checked by the column model
   typedef struct {
      step_kind_type    kind;
      logic [IDX_W-1:0] idx;
      logic [DIM_W-1:0] data;
      logic             restart;
      int               lit_n;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lap3d_req_if req_chan();
   lap3d_rsp_if rsp_chan();
   lap3d_csr_if csr_chan();

   laplacian_3d_csc_generator_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // grid extents as last written, and the generator's walk over the grid
   logic [DIM_W-1:0] grid_x_cfg = DIM_W'(1);
   logic [DIM_W-1:0] grid_y_cfg = DIM_W'(1);
   logic [DIM_W-1:0] grid_z_cfg = DIM_W'(1);
   logic [DIM_W-1:0] at_x;
   logic [DIM_W-1:0] at_y;
   logic [DIM_W-1:0] at_z;
   logic [COL_W-1:0] cols_done;
   logic [OFF_W-1:0] next_start;
   logic             matrix_done;

   lap_entry_type entries_due[$];       // entries still owed by the block, oldest first
   lap_entry_type literal_entries[$];   // hand-written entries for the plain directed rows
   step_type      directed_steps[$];

   int mismatches   = 0;
   int stall_asked  = 0;
   int stall_served = 0;
   int idle_cycles  = 0;
   bit quiet_phase  = 1'b0;          // no random gaps on either side while set

   // register values of 0 act as 1, values past the grid limit are clamped
   function automatic int used_extent(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > DIM_MAX) return DIM_MAX;
      return int'(v);
   endfunction

   function automatic void rewind_grid();
      at_x        = DIM_W'(1);
      at_y        = '0;
      at_z        = '0;
      cols_done   = '0;
      next_start  = OFF_W'(1);
      matrix_done = 1'b0;
   endfunction

   // works out the entries of the next column, queues them and advances the walk
   function automatic int predict_column(input logic restart);
      int               dx, dy, dz, n, k;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] rows [4];
      logic             x_edge, y_edge, z_edge, last_col;
      lap_entry_type    e;
      dx = used_extent(grid_x_cfg);
      dy = used_extent(grid_y_cfg);
      dz = used_extent(grid_z_cfg);
      if (restart) rewind_grid();
      if (matrix_done) return 0;
      col = cols_done + 1'b1;
      // a position at or past the last index counts as the edge
      x_edge   = int'(at_x) >= dx;
      y_edge   = int'(at_y) >= dy - 1;
      z_edge   = int'(at_z) >= dz - 1;
      last_col = x_edge && y_edge && z_edge;
      rows[0] = col;
      n = 1;
      if (!x_edge) begin
         rows[n] = col + 1'b1;
         n++;
      end
      if (!y_edge) begin
         rows[n] = COL_W'(col + dx);
         n++;
      end
      if (!z_edge) begin
         rows[n] = COL_W'(col + dx * dy);
         n++;
      end
      for (k = 0; k < n; k++) begin
         e.column         = col;
         e.row            = rows[k];
         e.entry_value    = (k == 0) ? VAL_DIAG : VAL_OFF;
         e.column_start   = next_start;
         e.rhs_value      = (cols_done == '0) || last_col;
         e.last_in_column = (k == n - 1);
         e.last_of_matrix = (k == n - 1) && last_col;
         entries_due.push_back(e);
      end
      next_start = next_start + OFF_W'(n);
      cols_done  = col;
      if (last_col) begin
         matrix_done = 1'b1;
      end else if (!x_edge) begin
         at_x = at_x + 1'b1;
      end else begin
         at_x = DIM_W'(1);
         if (!y_edge) begin
            at_y = at_y + 1'b1;
         end else begin
            at_y = '0;
            at_z = at_z + 1'b1;
         end
      end
      return n;
   endfunction

   function automatic lap_entry_type make_entry(input int col, input int row, input int value,
                                                input int start, input bit rhs, input bit lic,
                                                input bit lom);
      lap_entry_type e;
      e.column         = COL_W'(col);
      e.row            = COL_W'(row);
      e.entry_value    = 4'(value);
      e.column_start   = OFF_W'(start);
      e.rhs_value      = rhs;
      e.last_in_column = lic;
      e.last_of_matrix = lom;
      return e;
   endfunction

   function automatic void add_csr(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
      step_type s;
      s.kind    = STEP_CSR;
      s.idx     = idx;
      s.data    = data;
      s.restart = 1'b0;
      s.lit_n   = -1;
      directed_steps.push_back(s);
   endfunction

   function automatic void add_req(input logic restart, input int lit_n);
      step_type s;
      s.kind    = STEP_REQ;
      s.idx     = REG_DIM_X;
      s.data    = '0;
      s.restart = restart;
      s.lit_n   = lit_n;
      directed_steps.push_back(s);
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (quiet_phase) return 0;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // small grids mostly, so that matrices run to their end; now and then a clamp case
   function automatic logic [DIM_W-1:0] pick_extent();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0:       return '0;
         1:       return DIM_W'($urandom_range(257, 511));
         2:       return DIM_W'(DIM_MAX);
         3:       return DIM_W'($urandom_range(100, 255));
         default: return DIM_W'($urandom_range(1, 5));
      endcase
   endfunction

   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // offers one request item; valid stays high when the next item follows at once
   task automatic offer_request(input logic restart, input int lit_n, output int produced);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart;
      do @(posedge clock); while (!req_chan.ready);
      produced = predict_column(restart);
      // plain rows: the hand-written entries stand in for the model's
      if (lit_n >= 0) begin
         repeat (produced) void'(entries_due.pop_back());
         repeat (lit_n) entries_due.push_back(literal_entries.pop_front());
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender pause until every owed entry has come out
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (entries_due.size() != 0) @(posedge clock);
   endtask

   // extents change only with the block idle; a request after the end leaves no trace,
   // so after draining the task also waits out SETTLE_CYCLES before the write
   task automatic write_extent(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_DIM_X: grid_x_cfg = value;
         REG_DIM_Y: grid_y_cfg = value;
         REG_DIM_Z: grid_z_cfg = value;
         default:   ;
      endcase
   endtask

   // receiver: random ready with gaps, plus the long hold-off when asked for
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (stall_served != stall_asked) begin
            stall_served++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // each entry taken by the receiver against the oldest owed one
   always @(posedge clock) begin : check_entries
      lap_entry_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (entries_due.size() == 0) begin
            $error("unexpected item: column %0d row %0d", rsp_chan.column, rsp_chan.row);
            mismatches++;
         end else begin
            want = entries_due.pop_front();
            compare_field("column", want.column, rsp_chan.column);
            compare_field("row", want.row, rsp_chan.row);
            compare_field("entry_value", $signed(want.entry_value),
                          $signed(rsp_chan.entry_value));
            compare_field("column_start", want.column_start, rsp_chan.column_start);
            compare_field("rhs_value", want.rhs_value, rsp_chan.rhs_value);
            compare_field("last_in_column", want.last_in_column, rsp_chan.last_in_column);
            compare_field("last_of_matrix", want.last_of_matrix, rsp_chan.last_of_matrix);
         end
      end
   end

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      step_type s;
      int       produced, productive, phase, burst, i;
      logic     rs;

      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      csr_chan.valid   = 1'b0;
      csr_chan.index   = REG_DIM_X;
      csr_chan.data    = '0;
      rewind_grid();

      // out of reset the grid is a single point: one diagonal entry, first and last at once
      add_req(1'b0, 1);
      literal_entries.push_back(make_entry(1, 1, 6, 1, 1, 1, 1));
      // request after the end gives nothing
      add_req(1'b0, 0);
      // restart brings column 1 back in the same step
      add_req(1'b1, 1);
      literal_entries.push_back(make_entry(1, 1, 6, 1, 1, 1, 1));

      // zero extents act as one
      add_csr(REG_DIM_X, '0);
      add_csr(REG_DIM_Y, '0);
      add_csr(REG_DIM_Z, '0);
      add_req(1'b1, 1);
      literal_entries.push_back(make_entry(1, 1, 6, 1, 1, 1, 1));
      add_req(1'b0, 0);

      // largest grid: first column has all three neighbors
      add_csr(REG_DIM_X, DIM_W'(DIM_MAX));
      add_csr(REG_DIM_Y, DIM_W'(DIM_MAX));
      add_csr(REG_DIM_Z, DIM_W'(DIM_MAX));
      add_req(1'b1, 4);
      literal_entries.push_back(make_entry(1, 1, 6, 1, 1, 0, 0));
      literal_entries.push_back(make_entry(1, 2, -1, 1, 1, 0, 0));
      literal_entries.push_back(make_entry(1, 257, -1, 1, 1, 0, 0));
      literal_entries.push_back(make_entry(1, 65537, -1, 1, 1, 1, 0));
      add_req(1'b0, -1);
      add_req(1'b0, -1);

      // shrink the grid mid-run: x is already past its edge, walk still ends
      add_csr(REG_DIM_X, DIM_W'(2));
      add_csr(REG_DIM_Y, DIM_W'(2));
      add_csr(REG_DIM_Z, DIM_W'(2));
      repeat (8) add_req(1'b0, -1);

      // all-ones x clamps to the grid limit
      add_csr(REG_DIM_X, '1);
      add_csr(REG_DIM_Y, DIM_W'(3));
      add_csr(REG_DIM_Z, DIM_W'(1));
      add_req(1'b1, -1);
      add_req(1'b0, -1);
      add_req(1'b0, -1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (directed_steps.size() != 0) begin
         s = directed_steps.pop_front();
         if (s.kind == STEP_CSR) begin
            write_extent(s.idx, s.data);
         end else begin
            offer_request(s.restart, s.lit_n, produced);
         end
      end

      // random phases: new extents, mostly a restart, then a burst of column requests
      productive = 0;
      phase = 0;
      while (productive < RANDOM_COLS) begin
         if (phase == 1) begin
            // back-pressure phase: a mid-size grid while the receiver holds off
            write_extent(REG_DIM_X, DIM_W'(4));
            write_extent(REG_DIM_Y, DIM_W'(3));
            write_extent(REG_DIM_Z, DIM_W'(3));
            quiet_phase = 1'b1;
            stall_asked++;
            burst = 60;
         end else begin
            if (phase == 0 || $urandom_range(0, 2) != 0) write_extent(REG_DIM_X, pick_extent());
            if (phase == 0 || $urandom_range(0, 2) != 0) write_extent(REG_DIM_Y, pick_extent());
            if (phase == 0 || $urandom_range(0, 2) != 0) write_extent(REG_DIM_Z, pick_extent());
            quiet_phase = ($urandom_range(0, 4) == 0);
            burst = $urandom_range(5, 60);
         end
         for (i = 0; i < burst; i++) begin
            // without a leading restart the walk carries on under the new extents
            rs = (i == 0 && (phase == 1 || $urandom_range(0, 3) != 0)) ||
                 ($urandom_range(0, 40) == 0) ||
                 (matrix_done && $urandom_range(0, 3) == 0);
            offer_request(rs, -1, produced);
            if (produced > 0) productive++;
            if ($urandom_range(0, 49) == 0) wait_drained();
         end
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/lap3d_pkg.sv
rtl/core/lap3d_chan_if.sv
rtl/core/lap3d_front.sv
rtl/core/lap3d_queue.sv
rtl/core/lap3d_back.sv
rtl/core/laplacian_3d_csc_generator_top.sv
verif/laplacian_3d_csc_generator_top_tb.sv
